// ===== src/dpd_pkg.sv =====
`default_nettype none

package dpd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HIGH    = 2'd2,
    PH_LOW     = 2'd3
  } phase_t;

  localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_MISMATCH = 3'd2;
  localparam logic [2:0] KIND_EMPTY    = 3'd3;
  localparam logic [2:0] KIND_BREAK    = 3'd4;

  localparam logic [7:0] CH_OPEN  = 8'h24;
  localparam logic [7:0] CH_CLOSE = 8'h23;
  localparam logic [7:0] CH_BREAK = 8'h03;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] data;
    logic       cmd;
  } res_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad   = 1'b0;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== src/dpd_in_stage.sv =====
`default_nettype none

module dpd_in_stage
  import dpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       take,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== src/dpd_parser.sv =====
`default_nettype none

module dpd_parser
  import dpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       held_valid,
  input  wire logic [7:0] held_byte,
  input  wire logic       room,
  output logic            take,
  output res_t            res
);

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic       payload_seen, payload_seen_next;
  logic [3:0] high_digit, high_digit_next;
  logic       digit_bad, digit_bad_next;
  hex_t       hx;

  assign take = held_valid && room;
  assign hx   = hex_decode(held_byte);

  always_comb begin
    phase_next        = phase;
    running_sum_next  = running_sum;
    payload_seen_next = payload_seen;
    high_digit_next   = high_digit;
    digit_bad_next    = digit_bad;
    res               = '0;
    unique case (phase)
      PH_IDLE: begin
        if (held_byte == CH_OPEN) begin
          phase_next        = PH_PAYLOAD;
          running_sum_next  = 8'd0;
          payload_seen_next = 1'b0;
          high_digit_next   = 4'd0;
          digit_bad_next    = 1'b0;
        end else if (held_byte == CH_BREAK) begin
          res.valid = 1'b1;
          res.kind  = KIND_BREAK;
        end
      end
      PH_PAYLOAD: begin
        if (held_byte == CH_CLOSE) begin
          phase_next = PH_HIGH;
        end else begin
          running_sum_next  = running_sum + held_byte;
          payload_seen_next = 1'b1;
          res.valid         = 1'b1;
          res.kind          = KIND_PAYLOAD;
          res.data          = held_byte;
          res.cmd           = !payload_seen;
        end
      end
      PH_HIGH: begin
        phase_next = PH_LOW;
        if (hx.bad) begin
          digit_bad_next  = 1'b1;
          high_digit_next = 4'd0;
        end else begin
          high_digit_next = hx.value;
        end
      end
      PH_LOW: begin
        res.valid = 1'b1;
        if (digit_bad || hx.bad || {high_digit, hx.value} != running_sum) begin
          res.kind = KIND_MISMATCH;
        end else if (!payload_seen) begin
          res.kind = KIND_EMPTY;
        end else begin
          res.kind = KIND_GOOD;
        end
        phase_next        = PH_IDLE;
        running_sum_next  = 8'd0;
        payload_seen_next = 1'b0;
        high_digit_next   = 4'd0;
        digit_bad_next    = 1'b0;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      running_sum  <= 8'd0;
      payload_seen <= 1'b0;
      high_digit   <= 4'd0;
      digit_bad    <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      running_sum  <= running_sum_next;
      payload_seen <= payload_seen_next;
      high_digit   <= high_digit_next;
      digit_bad    <= digit_bad_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/dpd_out_stage.sv =====
`default_nettype none

module dpd_out_stage
  import dpd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  take,
  input  wire res_t  res,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [2:0] result_kind,
  output logic [7:0] payload_byte,
  output logic       is_command
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      result_kind  <= res.kind;
      payload_byte <= res.data;
      is_command   <= res.cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/debug_packet_deframer_unit.sv =====
// Debug link frame recovery ($payload#hh). Takes one received byte per cycle
// and gives at most one result item per byte: each payload byte (first one
// marked as the command), a verdict after the second checksum digit (good,
// mismatch, empty) and a break request for Ctrl-C outside a frame. A byte
// passes through an input register and a result register, so a result
// is registered when the parser takes its byte; throughput is one byte a
// cycle, held back only when the result register is full and not taken.
`default_nettype none

module debug_packet_deframer_unit
  import dpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      result_kind,
  output logic [7:0]      payload_byte,
  output logic            is_command
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       take;
  logic       room;
  res_t       res;

  dpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  dpd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .room       (room),
    .take       (take),
    .res        (res)
  );

  dpd_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .res          (res),
    .room         (room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .is_command   (is_command)
  );

endmodule

`default_nettype wire

// ===== src/dpd_checker.sv =====
`default_nettype none

module dpd_checker
  import dpd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] result_kind,
  input wire logic [7:0] payload_byte,
  input wire logic       is_command
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind)
      && $stable(payload_byte) && $stable(is_command))
    else $error("result item changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_kind <= KIND_BREAK)
    else $error("result kind out of range");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_PAYLOAD |-> payload_byte == 8'd0 && !is_command)
    else $error("non-payload item carries data");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item straight after reset");

endmodule

bind debug_packet_deframer_unit dpd_checker u_dpd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .payload_byte (payload_byte),
  .is_command   (is_command)
);

`default_nettype wire

// ===== verif/tb_debug_packet_deframer_unit.sv =====
module tb_debug_packet_deframer_unit;
  import dpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       cmd;
  } frame_result_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_stall_t;

  localparam int         BYTE_TARGET = 2000;
  localparam logic [7:0] CH_ACK      = 8'h2b;
  localparam logic [7:0] CH_NAK      = 8'h2d;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] result_kind;
  logic [7:0] payload_byte;
  logic       is_command;

  frame_result_t expected_results[$];
  phase_t        frame_phase;
  logic [7:0]    frame_sum;
  logic          frame_seen;
  logic [3:0]    frame_high;
  logic          frame_bad;

  int         errors;
  int         bytes_sent;
  int         hold_off;
  int         burst_left;
  bit         sender_gaps;
  rx_stall_t  rx_mode;
  logic [7:0] stall_pattern;

  debug_packet_deframer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .is_command   (is_command)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("debug_packet_deframer_unit test failed");
    $finish;
  end

  // {not hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      return 5'h10;
    end
    return {1'b0, v[3:0]};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h37 : 8'h57) + 8'(n);
  endfunction

  function void clear_frame();
    frame_sum  = 8'h00;
    frame_seen = 1'b0;
    frame_high = 4'h0;
    frame_bad  = 1'b0;
  endfunction

  function void predict_deframe(input logic [7:0] c);
    logic [4:0]    h;
    frame_result_t r;
    h = hex_digit(c);
    r = '0;
    case (frame_phase)
      PH_IDLE: begin
        if (c == CH_OPEN) begin
          clear_frame();
          frame_phase = PH_PAYLOAD;
        end else if (c == CH_BREAK) begin
          r.kind = KIND_BREAK;
          expected_results.push_back(r);
        end
      end
      PH_PAYLOAD: begin
        if (c == CH_CLOSE) begin
          frame_phase = PH_HIGH;
        end else begin
          r.kind = KIND_PAYLOAD;
          r.data = c;
          r.cmd  = !frame_seen;
          frame_sum  = frame_sum + c;
          frame_seen = 1'b1;
          expected_results.push_back(r);
        end
      end
      PH_HIGH: begin
        if (h[4]) begin
          frame_bad  = 1'b1;
          frame_high = 4'h0;
        end else begin
          frame_high = h[3:0];
        end
        frame_phase = PH_LOW;
      end
      default: begin
        if (frame_bad || h[4] || {frame_high, h[3:0]} != frame_sum) begin
          r.kind = KIND_MISMATCH;
        end else if (!frame_seen) begin
          r.kind = KIND_EMPTY;
        end else begin
          r.kind = KIND_GOOD;
        end
        expected_results.push_back(r);
        frame_phase = PH_IDLE;
        clear_frame();
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    rx_byte  = b;
    do @(posedge clk); while (!in_ready);
    predict_deframe(b);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(1, 5) : 0;
      repeat (gap) @(negedge clk) in_valid = 1'b0;
    end
  endtask

  task automatic send_frame();
    int         len;
    int         style;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] cs;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    sum = 8'h00;
    send_byte(CH_OPEN);
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (b == CH_CLOSE) b = CH_BREAK;
      sum = sum + b;
      send_byte(b);
    end
    send_byte(CH_CLOSE);
    style = $urandom_range(0, 9);
    cs = (style == 8) ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum;
    hi_c = hex_char(cs[7:4], 1'($urandom_range(0, 1)));
    lo_c = hex_char(cs[3:0], 1'($urandom_range(0, 1)));
    if (style == 9) begin
      if ($urandom_range(0, 1)) hi_c = 8'($urandom);
      else lo_c = 8'($urandom);
    end
    send_byte(hi_c);
    send_byte(lo_c);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: send_byte(CH_ACK);
        1: send_byte(CH_NAK);
        2: send_byte(CH_BREAK);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  task automatic test_directed();
    logic [7:0] seq[$];
    sender_gaps = 1'b0;
    rx_mode     = RX_FREE;
    // noise, break, empty frame, frame with '$' and Ctrl-C inside
    // and mixed-case checksum, frame with a non-hex high digit, empty frame with a bad checksum
    seq = '{CH_ACK, CH_NAK, 8'hff, 8'h00, CH_BREAK,
            CH_OPEN, CH_CLOSE, 8'h30, 8'h30,
            CH_OPEN, CH_OPEN, CH_BREAK, 8'hff, 8'h87, CH_CLOSE, 8'h61, 8'h44,
            CH_OPEN, CH_CLOSE, 8'h67, 8'h30,
            CH_OPEN, CH_CLOSE, 8'h30, 8'h31};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_frames();
    while (bytes_sent < BYTE_TARGET) begin
      sender_gaps = ($urandom_range(0, 2) != 0);
      rx_mode     = rx_stall_t'($urandom_range(0, 2));
      if ($urandom_range(0, 2) == 0) send_noise();
      send_frame();
    end
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    rx_mode     = RX_FREE;
    @(negedge clk) in_valid = 1'b0;
    hold_off = 300;
    repeat (5) send_frame();
  endtask

  initial begin
    out_ready     = 1'b0;
    stall_pattern = 8'b1011_0010;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ready = 1'b0;
        hold_off--;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ready = 1'b1;
          RX_RANDOM: out_ready = ($urandom_range(0, 2) != 0);
          default: begin
            stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
            out_ready = stall_pattern[0];
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: kind %0d byte %02h cmd %0d",
               result_kind, payload_byte, is_command);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
          errors++;
        end
        if (payload_byte !== want.data) begin
          $error("payload_byte: expected %02h, actual %02h", want.data, payload_byte);
          errors++;
        end
        if (is_command !== want.cmd) begin
          $error("is_command: expected %0d, actual %0d", want.cmd, is_command);
          errors++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    errors      = 0;
    bytes_sent  = 0;
    hold_off    = 0;
    burst_left  = 0;
    sender_gaps = 1'b0;
    rx_mode     = RX_FREE;
    frame_phase = PH_IDLE;
    clear_frame();
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random_frames();

    @(negedge clk) in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("debug_packet_deframer_unit test passed");
    end else begin
      $display("debug_packet_deframer_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/dpd_pkg.sv
src/dpd_in_stage.sv
src/dpd_parser.sv
src/dpd_out_stage.sv
src/debug_packet_deframer_unit.sv
src/dpd_checker.sv
verif/tb_debug_packet_deframer_unit.sv
